/* rtl/core/ypcd_pkg.sv */
// Shared constants, types and helper functions for the camera direction core.
package ypcd_pkg;

   // Configuration
   localparam int CORDIC_STEPS  = 16;
   localparam int OUT_FRAC_BITS = 15;

   localparam int TABLE_LEN  = 24;
   localparam int CORDIC_NUM = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int OUT_FRAC   = (OUT_FRAC_BITS > 30) ? 30 : OUT_FRAC_BITS;
   localparam int OUT_SHIFT  = 30 - OUT_FRAC;
   localparam int RND_SHIFT  = (OUT_SHIFT > 0) ? OUT_SHIFT - 1 : 0;

   // Shared step counter, wide enough for CORDIC, modulo and divide passes
   localparam int CNT_W = 5;

   // Angles in 1/65536 degree
   localparam logic [24:0]        FULL_TURN    = 25'd23592960;
   localparam logic [24:0]        QUARTER_TURN = 25'd5898240;
   localparam logic signed [23:0] PITCH_LIMIT  = 24'sd5832704;

   // Yaw wrap: bias by 256 turns, then conditional subtract of turns << 9 .. << 0
   localparam int               MOD_W      = 35;
   localparam int               MOD_STEPS  = 10;
   localparam logic [MOD_W-1:0] MOD_FULL   = MOD_W'(FULL_TURN);
   localparam logic [MOD_W-1:0] MOD_OFFSET = MOD_W'(64'd23592960 * 64'd256);

   // CORDIC gain start value in Q30
   localparam longint K_INF_Q30        = 652032874;
   localparam longint K_TWO_THIRDS_Q30 = 434688583;
   localparam logic signed [31:0] K_START =
      32'(K_INF_Q30 + (K_TWO_THIRDS_Q30 >>> (2 * CORDIC_NUM)));

   // Normalization divide
   localparam int LEN_W = 31;
   localparam int Q_W   = OUT_FRAC + 2;
   localparam int REM_W = OUT_FRAC + 32;

   // Register indexes
   localparam logic CSR_SENSITIVITY = 1'b0;
   localparam logic CSR_LOOK_ENABLE = 1'b1;

   typedef struct packed {
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic signed [15:0] forward_amount;
      logic signed [15:0] right_amount;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] move_x;
      logic signed [15:0] move_z;
      logic [24:0]        heading;
      logic signed [23:0] elevation;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [24:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_val;
      logic signed [31:0] sin_val;
   } cordic_rsp_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic [21:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic [21:0] val;
      case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767)       r = 16'sh7fff;
      else if (v < -64'sd32768) r = 16'sh8000;
      else                      r = v[15:0];
      return r;
   endfunction

   // Q30 to output format, round half up, saturate
   function automatic logic signed [15:0] round_out(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v;
      if (OUT_SHIFT > 0) t = (v + (64'sd1 <<< RND_SHIFT)) >>> OUT_SHIFT;
      return sat16(t);
   endfunction

endpackage

/* rtl/core/ypcd_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q30 datapath.
module ypcd_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  ypcd_pkg::cordic_req_type cor_req,
   output ypcd_pkg::cordic_rsp_type cor_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ypcd_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic signed [31:0]            x_ff, x_in, y_ff, y_in;
   logic signed [24:0]            z_ff, z_in;
   logic signed [31:0]            x_sh, y_sh;
   logic signed [24:0]            at;

   assign x_sh = x_ff >>> cnt_ff;
   assign y_sh = y_ff >>> cnt_ff;
   assign at   = $signed({3'b000, ypcd_pkg::atan_entry(cnt_ff)});

   // Step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cor_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = ypcd_pkg::K_START;
         y_in    = '0;
         z_in    = cor_req.angle;
      end else if (busy_ff) begin
         if (!z_ff[24]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ypcd_pkg::CNT_W'(ypcd_pkg::CORDIC_NUM - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign cor_rsp.done    = done_ff;
   assign cor_rsp.cos_val = x_ff;
   assign cor_rsp.sin_val = y_ff;

endmodule

/* rtl/core/yaw_pitch_camera_direction_core.sv */
// Top level: first-person camera yaw/pitch tracker with direction outputs.
//
// Usage:
//   req_* carries one beat of mouse deltas and forward/right movement.
//   rsp_* returns one beat per request: forward vector, normalized flat
//   movement direction, and the yaw/pitch held after the update.
//   csr_* writes sensitivity (index 0) and look enable (index 1); write only
//   while the core is idle.
// Timing:
//   req_ready is high only in idle. A request passes through angle update and
//   yaw wrap (skipped with look off), quadrant select, two 16-step CORDIC
//   passes on one shared unit, the multiply steps, a 32-step root, two 17-step
//   divides (skipped for zero movement) and the output load; a new request is
//   taken only after the previous result has been loaded.
//   The result sits in an output register, so a stalled receiver does not
//   block the next request; the sequencer waits only if the previous result
//   is still unread when the new one finishes.
// Reset:
//   Synchronous; yaw and pitch return to zero (looking along plus z),
//   sensitivity to 9830 and look enable to 0.
module yaw_pitch_camera_direction_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ypcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ypcd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   // Sequencer states
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_MDX  = 5'd1;
   localparam logic [4:0] ST_MDY  = 5'd2;
   localparam logic [4:0] ST_PIT  = 5'd3;
   localparam logic [4:0] ST_MOD  = 5'd4;
   localparam logic [4:0] ST_QUAD = 5'd5;
   localparam logic [4:0] ST_CYAW = 5'd6;
   localparam logic [4:0] ST_CPIT = 5'd7;
   localparam logic [4:0] ST_M1   = 5'd8;
   localparam logic [4:0] ST_M2   = 5'd9;
   localparam logic [4:0] ST_M3   = 5'd10;
   localparam logic [4:0] ST_M4   = 5'd11;
   localparam logic [4:0] ST_M5   = 5'd12;
   localparam logic [4:0] ST_M6   = 5'd13;
   localparam logic [4:0] ST_M7   = 5'd14;
   localparam logic [4:0] ST_M8   = 5'd15;
   localparam logic [4:0] ST_M9   = 5'd16;
   localparam logic [4:0] ST_SQRT = 5'd17;
   localparam logic [4:0] ST_DIV  = 5'd18;
   localparam logic [4:0] ST_DONE = 5'd19;

   localparam int CNT_W = ypcd_pkg::CNT_W;
   localparam int MOD_W = ypcd_pkg::MOD_W;
   localparam int LEN_W = ypcd_pkg::LEN_W;
   localparam int Q_W   = ypcd_pkg::Q_W;
   localparam int REM_W = ypcd_pkg::REM_W;

   logic [4:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   ypcd_pkg::req_type        req_ff, req_in;
   logic [15:0]              sens_ff, sens_in;
   logic                     look_ff, look_in;
   logic [24:0]              yaw_ff, yaw_in;
   logic signed [23:0]       pitch_ff, pitch_in;
   logic [MOD_W-1:0]         modv_ff, modv_in;
   logic [1:0]               quad_ff, quad_in;
   logic signed [31:0]       sy_ff, sy_in, cy_ff, cy_in, cp_ff, cp_in;
   logic signed [63:0]       prod_ff, acc_ff, acc_in;
   logic signed [31:0]       mx_ff, mx_in, mz_ff, mz_in;
   logic [63:0]              res_ff, res_in, bit_ff, bit_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic                     sel_ff, sel_in;
   logic signed [15:0]       dir_x_ff, dir_x_in, dir_y_ff, dir_y_in, dir_z_ff, dir_z_in;
   logic signed [15:0]       move_x_ff, move_x_in, move_z_ff, move_z_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ypcd_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   ypcd_pkg::cordic_req_type cor_req;
   ypcd_pkg::cordic_rsp_type cor_rsp;

   // Shared multiplier operands
   logic signed [31:0]       mul_a, mul_b;
   logic signed [63:0]       mul_p;

   // Helpers
   logic signed [35:0]       yaw_sum;
   logic signed [35:0]       pit_sum;
   logic [MOD_W-1:0]         mod_sub;
   logic [1:0]               quad_sel;
   logic [24:0]              quad_base;
   logic signed [63:0]       q30_val;
   logic signed [63:0]       mv_diff;
   logic signed [63:0]       mv_sum;
   logic [63:0]              sq_trial;
   logic [63:0]              sq_res_next, sq_bit_next;
   logic [REM_W-1:0]         div_sub;
   logic                     div_ge;
   logic [Q_W-1:0]           q_next;
   logic signed [31:0]       mag_src;
   logic [31:0]              mag_abs;
   logic [LEN_W-1:0]         len_src;
   logic [REM_W-1:0]         div_init;
   logic signed [31:0]       sgn_src;
   logic signed [Q_W:0]      q_signed;
   logic signed [15:0]       comp;
   logic                     load_rsp;

   ypcd_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cor_req (cor_req),
      .cor_rsp (cor_rsp)
   );

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MDX: begin
            mul_a = 32'(req_ff.delta_x);
            mul_b = $signed({16'd0, sens_ff});
         end
         ST_MDY: begin
            mul_a = 32'(req_ff.delta_y);
            mul_b = $signed({16'd0, sens_ff});
         end
         ST_M1: begin
            mul_a = sy_ff;
            mul_b = cp_ff;
         end
         ST_M2: begin
            mul_a = cy_ff;
            mul_b = cp_ff;
         end
         ST_M3: begin
            mul_a = 32'(req_ff.forward_amount);
            mul_b = sy_ff;
         end
         ST_M4: begin
            mul_a = 32'(req_ff.right_amount);
            mul_b = cy_ff;
         end
         ST_M5: begin
            mul_a = 32'(req_ff.forward_amount);
            mul_b = cy_ff;
         end
         ST_M6: begin
            mul_a = 32'(req_ff.right_amount);
            mul_b = sy_ff;
         end
         ST_M7: begin
            mul_a = mx_ff;
            mul_b = mx_ff;
         end
         ST_M8: begin
            mul_a = mz_ff;
            mul_b = mz_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Angle update datapath
   assign yaw_sum = $signed({11'd0, yaw_ff}) + $signed(prod_ff[35:0])
                  + $signed({1'b0, ypcd_pkg::MOD_OFFSET});
   assign pit_sum = $signed({{12{pitch_ff[23]}}, pitch_ff}) - $signed(prod_ff[35:0]);
   assign mod_sub = ypcd_pkg::MOD_FULL << cnt_ff;

   // Quadrant split of yaw
   always_comb begin
      if (yaw_ff >= 25'(3 * 5898240)) begin
         quad_sel  = 2'd3;
         quad_base = 25'(3 * 5898240);
      end else if (yaw_ff >= 25'(2 * 5898240)) begin
         quad_sel  = 2'd2;
         quad_base = 25'(2 * 5898240);
      end else if (yaw_ff >= ypcd_pkg::QUARTER_TURN) begin
         quad_sel  = 2'd1;
         quad_base = ypcd_pkg::QUARTER_TURN;
      end else begin
         quad_sel  = 2'd0;
         quad_base = '0;
      end
   end

   // Q60 product back to Q30, round half up
   assign q30_val = (prod_ff + (64'sd1 <<< 29)) >>> 30;
   assign mv_diff = (acc_ff - prod_ff) >>> 16;
   assign mv_sum  = (acc_ff + prod_ff) >>> 16;

   // Square root step
   assign sq_trial = res_ff + bit_ff;
   always_comb begin
      if (acc_ff >= sq_trial) begin
         sq_res_next = (res_ff >> 1) + bit_ff;
      end else begin
         sq_res_next = res_ff >> 1;
      end
      sq_bit_next = bit_ff >> 2;
   end

   // Divide step
   assign div_sub = REM_W'(len_ff) << cnt_ff;
   assign div_ge  = rem_ff >= div_sub;
   assign q_next  = {q_ff[Q_W-2:0], div_ge};

   // Divide setup: magnitude scaled plus half the length
   assign mag_src  = (state_ff == ST_SQRT) ? mx_ff : mz_ff;
   assign mag_abs  = mag_src[31] ? 32'(-mag_src) : 32'(mag_src);
   assign len_src  = (state_ff == ST_SQRT) ? res_in[LEN_W-1:0] : len_ff;
   assign div_init = (REM_W'(mag_abs[30:0]) << ypcd_pkg::OUT_FRAC) + REM_W'(len_src >> 1);

   // Signed normalized component
   assign sgn_src  = sel_ff ? mz_ff : mx_ff;
   assign q_signed = sgn_src[31] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
   assign comp     = ypcd_pkg::sat16(64'(q_signed));

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_in     = req_ff;
      yaw_in     = yaw_ff;
      pitch_in   = pitch_ff;
      modv_in    = modv_ff;
      quad_in    = quad_ff;
      sy_in      = sy_ff;
      cy_in      = cy_ff;
      cp_in      = cp_ff;
      acc_in     = acc_ff;
      mx_in      = mx_ff;
      mz_in      = mz_ff;
      res_in     = res_ff;
      bit_in     = bit_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      sel_in     = sel_ff;
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      dir_z_in   = dir_z_ff;
      move_x_in  = move_x_ff;
      move_z_in  = move_z_ff;
      cor_req.start = 1'b0;
      cor_req.angle = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = look_ff ? ST_MDX : ST_QUAD;
            end
         end
         ST_MDX: begin
            state_in = ST_MDY;
         end
         ST_MDY: begin
            modv_in  = yaw_sum[MOD_W-1:0];
            state_in = ST_PIT;
         end
         ST_PIT: begin
            if (pit_sum > 36'(ypcd_pkg::PITCH_LIMIT)) begin
               pitch_in = ypcd_pkg::PITCH_LIMIT;
            end else if (pit_sum < -36'(ypcd_pkg::PITCH_LIMIT)) begin
               pitch_in = -ypcd_pkg::PITCH_LIMIT;
            end else begin
               pitch_in = pit_sum[23:0];
            end
            cnt_in   = CNT_W'(ypcd_pkg::MOD_STEPS - 1);
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (modv_ff >= mod_sub) modv_in = modv_ff - mod_sub;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               yaw_in   = modv_in[24:0];
               state_in = ST_QUAD;
            end
         end
         ST_QUAD: begin
            quad_in       = quad_sel;
            cor_req.start = 1'b1;
            cor_req.angle = $signed(yaw_ff - quad_base);
            state_in      = ST_CYAW;
         end
         ST_CYAW: begin
            if (cor_rsp.done) begin
               case (quad_ff)
                  2'd0: begin
                     sy_in = cor_rsp.sin_val;
                     cy_in = cor_rsp.cos_val;
                  end
                  2'd1: begin
                     sy_in = cor_rsp.cos_val;
                     cy_in = -cor_rsp.sin_val;
                  end
                  2'd2: begin
                     sy_in = -cor_rsp.sin_val;
                     cy_in = -cor_rsp.cos_val;
                  end
                  default: begin
                     sy_in = -cor_rsp.cos_val;
                     cy_in = cor_rsp.sin_val;
                  end
               endcase
               cor_req.start = 1'b1;
               cor_req.angle = 25'(pitch_ff);
               state_in      = ST_CPIT;
            end
         end
         ST_CPIT: begin
            if (cor_rsp.done) begin
               cp_in    = cor_rsp.cos_val;
               dir_y_in = ypcd_pkg::round_out(64'(cor_rsp.sin_val));
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            state_in = ST_M2;
         end
         ST_M2: begin
            dir_x_in = ypcd_pkg::round_out(q30_val);
            state_in = ST_M3;
         end
         ST_M3: begin
            dir_z_in = ypcd_pkg::round_out(q30_val);
            state_in = ST_M4;
         end
         ST_M4: begin
            acc_in   = prod_ff;
            state_in = ST_M5;
         end
         ST_M5: begin
            mx_in    = mv_diff[31:0];
            state_in = ST_M6;
         end
         ST_M6: begin
            acc_in   = prod_ff;
            state_in = ST_M7;
         end
         ST_M7: begin
            mz_in    = mv_sum[31:0];
            state_in = ST_M8;
         end
         ST_M8: begin
            acc_in   = prod_ff;
            state_in = ST_M9;
         end
         ST_M9: begin
            acc_in   = acc_ff + prod_ff;
            res_in   = '0;
            bit_in   = 64'd1 << 62;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (acc_ff >= sq_trial) acc_in = acc_ff - sq_trial;
            res_in = sq_res_next;
            bit_in = sq_bit_next;
            if (bit_ff[0]) begin
               len_in = res_in[LEN_W-1:0];
               if ((req_ff.forward_amount == '0 && req_ff.right_amount == '0)
                   || res_in[LEN_W-1:0] == '0) begin
                  move_x_in = '0;
                  move_z_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  rem_in   = div_init;
                  q_in     = '0;
                  sel_in   = 1'b0;
                  cnt_in   = CNT_W'(Q_W - 1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_ge) rem_in = rem_ff - div_sub;
            q_in   = q_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (!sel_ff) begin
                  move_x_in = comp;
                  rem_in    = div_init;
                  q_in      = '0;
                  sel_in    = 1'b1;
                  cnt_in    = CNT_W'(Q_W - 1);
               end else begin
                  move_z_in = comp;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      sens_in = sens_ff;
      look_in = look_ff;
      if (csr_we) begin
         unique case (csr_index)
            ypcd_pkg::CSR_SENSITIVITY: sens_in = csr_wdata;
            ypcd_pkg::CSR_LOOK_ENABLE: look_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.dir_x     = dir_x_ff;
         rsp_data_in.dir_y     = dir_y_ff;
         rsp_data_in.dir_z     = dir_z_ff;
         rsp_data_in.move_x    = move_x_ff;
         rsp_data_in.move_z    = move_z_ff;
         rsp_data_in.heading   = yaw_ff;
         rsp_data_in.elevation = pitch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sens_ff      <= 16'd9830;
         look_ff      <= 1'b0;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sens_ff      <= sens_in;
         look_ff      <= look_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      req_ff      <= req_in;
      modv_ff     <= modv_in;
      quad_ff     <= quad_in;
      sy_ff       <= sy_in;
      cy_ff       <= cy_in;
      cp_ff       <= cp_in;
      prod_ff     <= mul_p;
      acc_ff      <= acc_in;
      mx_ff       <= mx_in;
      mz_ff       <= mz_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      len_ff      <= len_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      sel_ff      <= sel_in;
      dir_x_ff    <= dir_x_in;
      dir_y_ff    <= dir_y_in;
      dir_z_ff    <= dir_z_in;
      move_x_ff   <= move_x_in;
      move_z_ff   <= move_z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the camera yaw/pitch direction core.
module tb_top;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int LONG_HOLD      = 700;
   localparam int TAIL_CYCLES    = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ypcd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ypcd_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic              csr_index = ypcd_pkg::CSR_SENSITIVITY;
   logic [15:0]       csr_wdata = '0;

   yaw_pitch_camera_direction_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow state of the core
   int unsigned sens_shadow;
   bit          look_shadow;
   longint      yaw_shadow;
   longint      pitch_shadow;

   ypcd_pkg::rsp_type expected_rsp[$];
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      hold_left      = 0;
   int      fail_count     = 0;
   int      beats_sent     = 0;
   int      beats_checked  = 0;
   int      quiet_cycles   = 0;

   // ---------------- direction predictor ----------------
   function automatic void cordic_rotate(input longint ang, output longint c,
                                         output longint s);
      longint x, y, z, dx, dy, t;
      x = ypcd_pkg::K_INF_Q30
        + (ypcd_pkg::K_TWO_THIRDS_Q30 >>> (2 * ypcd_pkg::CORDIC_NUM));
      y = 0;
      z = ang;
      for (int i = 0; i < ypcd_pkg::CORDIC_NUM; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         t  = longint'(ypcd_pkg::atan_entry(ypcd_pkg::CNT_W'(i)));
         if (z >= 0) begin
            x -= dx; y += dy; z -= t;
         end else begin
            x += dx; y -= dy; z += t;
         end
      end
      c = x;
      s = y;
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint q30_out(input longint v);
      int sh;
      sh = 30 - ypcd_pkg::OUT_FRAC;
      if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      return clamp16(v);
   endfunction

   function automatic longint q60_q30(input longint p);
      return (p + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unit_comp(input longint v, input longint unsigned len);
      longint unsigned mag, q;
      mag = (v < 0) ? longint'(-v) : v;
      q   = ((mag << ypcd_pkg::OUT_FRAC) + len / 2) / len;
      return clamp16((v < 0) ? -longint'(q) : longint'(q));
   endfunction

   // Updates the shadow angles and returns the beat the core should produce
   function automatic ypcd_pkg::rsp_type predict_direction(input ypcd_pkg::req_type item);
      ypcd_pkg::rsp_type r;
      longint dxv, dyv, fv, rv, yv, pv, quad, rem, cr, sr, cy, sy, cp, sp, mx, mz;
      longint unsigned len;
      dxv = item.delta_x;
      dyv = item.delta_y;
      fv  = item.forward_amount;
      rv  = item.right_amount;
      if (look_shadow) begin
         yv = (yaw_shadow + dxv * longint'(sens_shadow)) % longint'(ypcd_pkg::FULL_TURN);
         pv = pitch_shadow - dyv * longint'(sens_shadow);
         if (yv < 0) yv += longint'(ypcd_pkg::FULL_TURN);
         if (pv > longint'(ypcd_pkg::PITCH_LIMIT)) pv = ypcd_pkg::PITCH_LIMIT;
         if (pv < -longint'(ypcd_pkg::PITCH_LIMIT)) pv = -longint'(ypcd_pkg::PITCH_LIMIT);
         yaw_shadow   = yv;
         pitch_shadow = pv;
      end
      // yaw: fold into a quadrant, rotate the remainder
      quad = yaw_shadow / longint'(ypcd_pkg::QUARTER_TURN);
      rem  = yaw_shadow - quad * longint'(ypcd_pkg::QUARTER_TURN);
      cordic_rotate(rem, cr, sr);
      case (quad & 3)
         0:       begin sy = sr;  cy = cr;  end
         1:       begin sy = cr;  cy = -sr; end
         2:       begin sy = -sr; cy = -cr; end
         default: begin sy = -cr; cy = sr;  end
      endcase
      cordic_rotate(pitch_shadow, cp, sp);
      r.dir_x = 16'(q30_out(q60_q30(sy * cp)));
      r.dir_y = 16'(q30_out(sp));
      r.dir_z = 16'(q30_out(q60_q30(cy * cp)));
      // flat movement, normalized
      mx  = (fv * sy - rv * cy) >>> 16;
      mz  = (fv * cy + rv * sy) >>> 16;
      len = root_floor(longint'(mx * mx) + longint'(mz * mz));
      if ((fv == 0 && rv == 0) || len == 0) begin
         r.move_x = '0;
         r.move_z = '0;
      end else begin
         r.move_x = 16'(unit_comp(mx, len));
         r.move_z = 16'(unit_comp(mz, len));
      end
      r.heading   = 25'(yaw_shadow);
      r.elevation = 24'(pitch_shadow);
      return r;
   endfunction

   // ---------------- driving ----------------
   task automatic send_beat(input ypcd_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      expected_rsp.push_back(predict_direction(item));
      beats_sent++;
   endtask

   task automatic send_fields(input int dx, input int dy, input int fw, input int rt);
      ypcd_pkg::req_type item;
      item.delta_x        = 16'(dx);
      item.delta_y        = 16'(dy);
      item.forward_amount = 16'(fw);
      item.right_amount   = 16'(rt);
      send_beat(item);
   endtask

   // Lower valid and wait until every result is back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == ypcd_pkg::CSR_SENSITIVITY) sens_shadow = val;
      else                                  look_shadow = val[0];
   endtask

   function automatic ypcd_pkg::req_type random_item;
      ypcd_pkg::req_type item;
      item = ypcd_pkg::req_type'({$urandom, $urandom});
      // mostly modest mouse motion so pitch is not always pinned
      if ($urandom_range(3) != 0) begin
         item.delta_x = 16'($signed($urandom_range(400)) - 200);
         item.delta_y = 16'($signed($urandom_range(200)) - 100);
      end
      case ($urandom_range(9))
         0: begin item.forward_amount = '0; item.right_amount = '0; end
         1: item.right_amount = '0;
         2: item.forward_amount = '0;
         3: begin
            item.forward_amount = 16'($signed($urandom_range(4)) - 2);
            item.right_amount   = 16'($signed($urandom_range(4)) - 2);
         end
         default: ;
      endcase
      return item;
   endfunction

   // ---------------- receiver and checking ----------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t %s expected %0d got %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      ypcd_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t unexpected result beat %p", $time, rsp_data);
            fail_count++;
         end else begin
            exp_r = expected_rsp.pop_front();
            check_field("dir_x", exp_r.dir_x, rsp_data.dir_x);
            check_field("dir_y", exp_r.dir_y, rsp_data.dir_y);
            check_field("dir_z", exp_r.dir_z, rsp_data.dir_z);
            check_field("move_x", exp_r.move_x, rsp_data.move_x);
            check_field("move_z", exp_r.move_z, rsp_data.move_z);
            check_field("heading", exp_r.heading, rsp_data.heading);
            check_field("elevation", exp_r.elevation, rsp_data.elevation);
            beats_checked++;
         end
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no progress, %0d results outstanding", $time,
                  expected_rsp.size());
         $display("yaw_pitch_camera_direction_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed;
      // look disabled: angles stay put, movement extremes and zero movement
      send_fields(32767, 32767, 0, 0);
      send_fields(-32768, -32768, 32767, 0);
      send_fields(0, 0, -32768, -32768);
      send_fields(0, 0, 0, 1);
      send_fields(0, 0, 1, -1);
      send_fields(0, 0, 32767, 32767);
      // exact quarter turns
      write_reg(ypcd_pkg::CSR_LOOK_ENABLE, 16'd1);
      write_reg(ypcd_pkg::CSR_SENSITIVITY, 16'd16384);
      repeat (4) send_fields(360, 0, 32767, -32768);
      send_fields(-360, 0, 1000, 2000);
      send_fields(-1, 0, 0, 32767);
      // pitch overrun both ways, then yaw wrap with full scale
      write_reg(ypcd_pkg::CSR_SENSITIVITY, 16'hFFFF);
      send_fields(0, 32767, 5, 0);
      send_fields(0, -32768, 0, 5);
      send_fields(32767, 1, -32768, 32767);
      send_fields(-32768, -1, 300, -300);
      write_reg(ypcd_pkg::CSR_SENSITIVITY, 16'd0);
      send_fields(-32768, 32767, 12345, -23456);
      write_reg(ypcd_pkg::CSR_SENSITIVITY, 16'd1);
      send_fields(1, -1, -1, 0);
      send_fields(-1, 1, 0, 0);
   endtask

   task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
      drain();
      write_reg(ypcd_pkg::CSR_SENSITIVITY, ($urandom_range(3) == 0) ?
                16'($urandom) : 16'($urandom_range(20000)));
      write_reg(ypcd_pkg::CSR_LOOK_ENABLE, 16'($urandom_range(5) != 0));
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) send_beat(random_item());
   endtask

   task automatic test_backpressure;
      drain();
      hold_left = LONG_HOLD;
      send_idle_pct = 0;
      repeat (12) send_beat(random_item());
      // pause until the core has delivered everything
      drain();
      repeat (12) send_beat(random_item());
   endtask

   initial begin
      sens_shadow  = 9830;
      look_shadow  = 1'b0;
      yaw_shadow   = 0;
      pitch_shadow = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(400, 0, 0);
      test_random_phase(400, 77, 0);
      test_random_phase(400, 0, 77);
      test_random_phase(400, 33, 33);
      test_random_phase(300, 0, 0);
      test_backpressure();
      write_reg(ypcd_pkg::CSR_LOOK_ENABLE, 16'd0);
      test_random_phase(50, 33, 33);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d request beats, %0d results checked, over look on/off,",
               beats_sent, beats_checked);
      $display("sensitivity extremes, quarter turns, wrap, clamp and stall phases");
      if (fail_count == 0 && expected_rsp.size() == 0)
         $display("yaw_pitch_camera_direction_core: match");
      else
         $display("yaw_pitch_camera_direction_core: mismatch");
      $finish;
   end

endmodule
